FILE: rtl/urrb_pkg.sv
// Package for the UART receive ring buffer: depth, index widths, escape codes,
// operation codes and the byte store port structs. No dependencies.
`default_nettype none

package urrb_pkg;

  localparam int Depth = 32;
  localparam int IdxW  = $clog2(Depth);
  // wide enough for read index plus peek offset and for fill compares
  localparam int SumW  = ((IdxW > 5) ? IdxW : 5) + 1;

  localparam logic [7:0] EscFirst  = 8'h40;  // '@'
  localparam logic [7:0] EscSecond = 8'h52;  // 'R'
  localparam logic [7:0] CntMax    = 8'hff;

  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [7:0]      data;
  } ram_wr_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } ram_rd_t;

endpackage

`default_nettype wire

FILE: rtl/urrb_ram.sv
// Byte store of the receive ring buffer: one write port, one read port with
// registered read data. Depends on urrb_pkg.
`default_nettype none

module urrb_ram (
  input  wire logic               clk_i,
  input  wire urrb_pkg::ram_wr_t  wr_i,
  input  wire urrb_pkg::ram_rd_t  rd_i,
  output logic [7:0]              rd_data_o
);

  logic [7:0] mem_q [urrb_pkg::Depth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_o <= mem_q[rd_i.addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uart_receive_ring_buffer.sv
// UART receive ring buffer: receive, pop, peek and flush on a byte store.
// The result word is registered and shown in the cycle after its command is accepted.
// Throughput: one command per cycle; the store has a registered read port, and a
// waiting result stalls input until it is taken.
// Reset: indices, overflow count and last byte clear at once; the store is not
// cleared, entries are read only after being written. Depends on urrb_pkg, urrb_ram.
`default_nettype none

module uart_receive_ring_buffer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] operation_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [4:0] peek_offset_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            data_valid_o,
  output logic [7:0]      data_byte_o,
  output logic [4:0]      fill_count_o,
  output logic [7:0]      overflow_count_o,
  output logic            reset_request_o
);

  localparam int IdxW = urrb_pkg::IdxW;
  localparam int SumW = urrb_pkg::SumW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(urrb_pkg::Depth - 1);

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    res = (idx == LastIdx) ? '0 : idx + 1'b1;
    return res;
  endfunction

  function automatic logic [IdxW-1:0] fill_of(input logic [IdxW-1:0] w,
                                              input logic [IdxW-1:0] r);
    logic [IdxW:0] diff;
    logic [IdxW:0] wrapped;
    diff    = {1'b0, w} - {1'b0, r};
    wrapped = diff + (IdxW+1)'(urrb_pkg::Depth);
    return (w >= r) ? diff[IdxW-1:0] : wrapped[IdxW-1:0];
  endfunction

  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [7:0]      drop_q, drop_d;
  logic [7:0]      prev_q, prev_d;

  logic            out_valid_q;
  logic            dvalid_q, dvalid_d;
  logic [4:0]      fill_q;
  logic [7:0]      ovf_q;
  logic            rreq_q, rreq_d;

  logic            accept;
  urrb_pkg::op_e   op;
  urrb_pkg::ram_wr_t wr;
  urrb_pkg::ram_rd_t rd;
  logic [7:0]      rd_data;

  logic [IdxW-1:0] fill_cur;
  logic [IdxW-1:0] fill_new;
  logic [IdxW+4:0] fill_ext;
  logic [SumW-1:0] pos_sum;
  logic [SumW-1:0] pos_wrap;
  logic [IdxW-1:0] next_wr;
  logic            esc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = urrb_pkg::op_e'(operation_i);

  always_comb begin
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    drop_d   = drop_q;
    prev_d   = prev_q;
    dvalid_d = 1'b0;
    rreq_d   = 1'b0;
    wr       = '{en: 1'b0, addr: wr_idx_q, data: rx_byte_i};
    rd       = '{en: 1'b0, addr: rd_idx_q};
    fill_cur = fill_of(wr_idx_q, rd_idx_q);
    next_wr  = wrap_inc(wr_idx_q);
    esc      = (rx_byte_i == urrb_pkg::EscSecond) && (prev_q == urrb_pkg::EscFirst);
    pos_sum  = SumW'(rd_idx_q) + SumW'(peek_offset_i);
    pos_wrap = (pos_sum >= SumW'(urrb_pkg::Depth)) ?
               pos_sum - SumW'(urrb_pkg::Depth) : pos_sum;

    if (accept) begin
      unique case (op)
        urrb_pkg::OP_RECV: begin
          prev_d = rx_byte_i;
          if (esc) begin
            rreq_d = 1'b1;
          end else if (next_wr == rd_idx_q) begin
            if (drop_q != urrb_pkg::CntMax) begin
              drop_d = drop_q + 8'd1;
            end
          end else begin
            wr.en    = 1'b1;
            wr_idx_d = next_wr;
          end
        end
        urrb_pkg::OP_POP: begin
          if (wr_idx_q != rd_idx_q) begin
            dvalid_d = 1'b1;
            rd.en    = 1'b1;
            rd_idx_d = wrap_inc(rd_idx_q);
          end
        end
        urrb_pkg::OP_PEEK: begin
          if (SumW'(peek_offset_i) < SumW'(fill_cur)) begin
            dvalid_d = 1'b1;
            rd.en    = 1'b1;
            rd.addr  = pos_wrap[IdxW-1:0];
          end
        end
        urrb_pkg::OP_FLUSH: begin
          rd_idx_d = '0;
          wr_idx_d = '0;
          drop_d   = '0;
        end
        default: begin
        end
      endcase
    end

    fill_new = fill_of(wr_idx_d, rd_idx_d);
    fill_ext = {5'b0, fill_new};
  end

  urrb_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      drop_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      drop_q   <= drop_d;
      prev_q   <= prev_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dvalid_q <= dvalid_d;
      fill_q   <= fill_ext[4:0];
      ovf_q    <= drop_d;
      rreq_q   <= rreq_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_valid_o     = dvalid_q;
  assign data_byte_o      = dvalid_q ? rd_data : 8'd0;
  assign fill_count_o     = fill_q;
  assign overflow_count_o = ovf_q;
  assign reset_request_o  = rreq_q;

endmodule

`default_nettype wire

FILE: rtl/urrb_checker.sv
// Port-level checks for the UART receive ring buffer, bound to the top level.
// Depends on urrb_pkg and uart_receive_ring_buffer.
`default_nettype none

module urrb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic [1:0] operation_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       data_valid_o,
  input wire logic [7:0] data_byte_o,
  input wire logic [4:0] fill_count_o,
  input wire logic [7:0] overflow_count_o,
  input wire logic       reset_request_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(fill_count_o))
    else $error("result word changed while stalled");

  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o |-> data_byte_o == 8'd0)
    else $error("invalid result carries nonzero byte");

  a_rreq_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_request_o |-> !data_valid_o)
    else $error("reset request with data");

  a_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == urrb_pkg::OP_FLUSH |=>
      out_valid_o && fill_count_o == 5'd0 && overflow_count_o == 8'd0
      && !data_valid_o)
    else $error("flush did not empty the buffer");

endmodule

bind uart_receive_ring_buffer urrb_checker u_urrb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .operation_i      (operation_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .data_valid_o     (data_valid_o),
  .data_byte_o      (data_byte_o),
  .fill_count_o     (fill_count_o),
  .overflow_count_o (overflow_count_o),
  .reset_request_o  (reset_request_o)
);

`default_nettype wire

FILE: test/tb.sv
// Testbench for uart_receive_ring_buffer. Sends receive, pop, peek and flush words
// and checks every result word against a ring buffer predictor kept in the bench.
// Depends on urrb_pkg and the buffer RTL.
module tb;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [4:0] fill_count;
    logic [7:0] overflow_count;
    logic       reset_request;
  } result_t;

  localparam int IdleLimit = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] operation_i = urrb_pkg::OP_RECV;
  logic [7:0] rx_byte_i = 8'h00;
  logic [4:0] peek_offset_i = 5'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       data_valid_o;
  logic [7:0] data_byte_o;
  logic [4:0] fill_count_o;
  logic [7:0] overflow_count_o;
  logic       reset_request_o;

  // predictor state
  logic [7:0] shadow [urrb_pkg::Depth];
  int         head = 0;
  int         tail = 0;
  logic [7:0] drops = 8'h00;
  logic [7:0] last_rx = 8'h00;

  result_t    expected_words[$];
  int         errors = 0;
  int         idle_cycles = 0;
  logic       no_idle = 1'b0;

  uart_receive_ring_buffer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .rx_byte_i       (rx_byte_i),
    .peek_offset_i   (peek_offset_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .data_valid_o    (data_valid_o),
    .data_byte_o     (data_byte_o),
    .fill_count_o    (fill_count_o),
    .overflow_count_o(overflow_count_o),
    .reset_request_o (reset_request_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int stored();
    return (tail - head + urrb_pkg::Depth) % urrb_pkg::Depth;
  endfunction

  function automatic result_t buffer_after(urrb_pkg::op_e op, logic [7:0] rx,
                                           logic [4:0] offset);
    result_t r;
    int      next;
    r = '0;
    case (op)
      urrb_pkg::OP_RECV: begin
        if (rx == urrb_pkg::EscSecond && last_rx == urrb_pkg::EscFirst) begin
          r.reset_request = 1'b1;
        end else begin
          next = (tail + 1) % urrb_pkg::Depth;
          if (next == head) begin
            if (drops != urrb_pkg::CntMax) drops = drops + 8'd1;
          end else begin
            shadow[tail] = rx;
            tail = next;
          end
        end
        last_rx = rx;
      end
      urrb_pkg::OP_POP: begin
        if (tail != head) begin
          r.data_valid = 1'b1;
          r.data_byte = shadow[head];
          head = (head + 1) % urrb_pkg::Depth;
        end
      end
      urrb_pkg::OP_PEEK: begin
        if (int'(offset) < stored()) begin
          r.data_valid = 1'b1;
          r.data_byte = shadow[(head + int'(offset)) % urrb_pkg::Depth];
        end
      end
      default: begin
        head = 0;
        tail = 0;
        drops = 8'h00;
      end
    endcase
    r.fill_count = 5'(stored());
    r.overflow_count = drops;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return urrb_pkg::EscFirst;
    if (roll < 22) return urrb_pkg::EscSecond;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_word(urrb_pkg::op_e op, logic [7:0] rx, logic [4:0] offset);
    int gap;
    in_valid_i <= 1'b1;
    operation_i <= op;
    rx_byte_i <= rx;
    peek_offset_i <= offset;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_words.push_back(buffer_after(op, rx, offset));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_basic_ops();
    send_word(urrb_pkg::OP_POP, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_PEEK, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_RECV, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_RECV, 8'hff, 5'd31);
    send_word(urrb_pkg::OP_RECV, 8'ha5, 5'd0);
    send_word(urrb_pkg::OP_PEEK, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_PEEK, 8'h00, 5'd2);
    send_word(urrb_pkg::OP_PEEK, 8'h00, 5'd3);
    send_word(urrb_pkg::OP_PEEK, 8'hff, 5'd31);
    send_word(urrb_pkg::OP_POP, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_POP, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_POP, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_POP, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_FLUSH, 8'h00, 5'd0);
  endtask

  task automatic test_escape();
    send_word(urrb_pkg::OP_RECV, urrb_pkg::EscFirst, 5'd0);
    send_word(urrb_pkg::OP_RECV, urrb_pkg::EscSecond, 5'd0);
    send_word(urrb_pkg::OP_RECV, urrb_pkg::EscSecond, 5'd0);
    send_word(urrb_pkg::OP_RECV, urrb_pkg::EscFirst, 5'd0);
    send_word(urrb_pkg::OP_RECV, urrb_pkg::EscFirst, 5'd0);
    send_word(urrb_pkg::OP_RECV, urrb_pkg::EscSecond, 5'd0);
    // last byte survives a flush
    send_word(urrb_pkg::OP_RECV, urrb_pkg::EscFirst, 5'd0);
    send_word(urrb_pkg::OP_FLUSH, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_RECV, urrb_pkg::EscSecond, 5'd0);
    send_word(urrb_pkg::OP_FLUSH, 8'h00, 5'd0);
  endtask

  task automatic test_overflow_saturation();
    for (int i = 0; i < urrb_pkg::Depth - 1; i++) begin
      send_word(urrb_pkg::OP_RECV, pick_byte(), 5'd0);
    end
    send_word(urrb_pkg::OP_PEEK, 8'h00, 5'(urrb_pkg::Depth - 2));
    send_word(urrb_pkg::OP_PEEK, 8'h00, 5'd0);
    for (int i = 0; i < 270; i++) send_word(urrb_pkg::OP_RECV, pick_byte(), 5'd0);
    send_word(urrb_pkg::OP_POP, 8'h00, 5'd0);
    send_word(urrb_pkg::OP_RECV, 8'h5a, 5'd0);
    send_word(urrb_pkg::OP_RECV, 8'h5b, 5'd0);
    send_word(urrb_pkg::OP_FLUSH, 8'h00, 5'd0);
  endtask

  task automatic test_random_traffic();
    int  bias;
    int  roll;
    int  recv_pct;
    urrb_pkg::op_e op;
    logic [4:0] offset;
    bias = 0;
    for (int i = 0; i < 170; i++) begin
      if (i % 50 == 0) bias = $urandom_range(0, 2);
      no_idle = (i >= 70 && i < 110);
      if (i % 60 == 59) wait_drained();
      recv_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 45;
      roll = $urandom_range(0, 99);
      if (roll < recv_pct) op = urrb_pkg::OP_RECV;
      else if (roll >= 97) op = urrb_pkg::OP_FLUSH;
      else if ($urandom_range(0, 2) == 0) op = urrb_pkg::OP_PEEK;
      else op = urrb_pkg::OP_POP;
      if ($urandom_range(0, 3) != 0) offset = 5'($urandom_range(0, stored()));
      else offset = 5'($urandom_range(0, 31));
      send_word(op, pick_byte(), offset);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_escape();
    wait_drained();
    test_overflow_saturation();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (5) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int gap;
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result word with none pending", fill_count_o, 0);
      end else begin
        want = expected_words.pop_front();
        if (data_valid_o !== want.data_valid)
          report_mismatch("data_valid", data_valid_o, want.data_valid);
        if (data_byte_o !== want.data_byte)
          report_mismatch("data_byte", data_byte_o, want.data_byte);
        if (fill_count_o !== want.fill_count)
          report_mismatch("fill_count", fill_count_o, want.fill_count);
        if (overflow_count_o !== want.overflow_count)
          report_mismatch("overflow_count", overflow_count_o, want.overflow_count);
        if (reset_request_o !== want.reset_request)
          report_mismatch("reset_request", reset_request_o, want.reset_request);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no word moved for %0d cycles", IdleLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
